[rtl/msf_pkg.sv]
package msf_pkg;

   // Default geometry of the slot ring
   localparam int QUEUE_SLOTS_DEF = 16;
   localparam int SLOT_BYTES_DEF  = 64;

   // Fixed field widths
   localparam int BYTE_W = 8;
   localparam int CHAN_W = 16;
   localparam int LEN_W  = 7;
   localparam int CODE_W = 2;

   // Request modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Result kinds
   localparam logic [CODE_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [CODE_W-1:0] KIND_BYTE   = 2'd1;
   localparam logic [CODE_W-1:0] KIND_EMPTY  = 2'd2;

   // Write status codes
   localparam logic [CODE_W-1:0] ST_OK   = 2'd0;
   localparam logic [CODE_W-1:0] ST_FULL = 2'd1;
   localparam logic [CODE_W-1:0] ST_LONG = 2'd2;

   // Memory strobes from the controller
   typedef struct packed {
      logic pay_we;
      logic pay_re;
      logic meta_we;
      logic meta_re;
   } mem_ctl_type;

endpackage

[rtl/msf_slot_mem.sv]
module msf_slot_mem
   import msf_pkg::*;
#(
   parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
   parameter int SLOT_BYTES  = SLOT_BYTES_DEF,
   localparam int SW = $clog2(QUEUE_SLOTS),
   localparam int AW = $clog2(QUEUE_SLOTS * SLOT_BYTES)
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [AW-1:0]     pay_waddr,
   input  logic [BYTE_W-1:0] pay_wdata,
   input  logic [AW-1:0]     pay_raddr,
   output logic [BYTE_W-1:0] pay_rdata,
   input  logic [SW-1:0]     meta_waddr,
   input  logic [LEN_W-1:0]  meta_wlen,
   input  logic [CHAN_W-1:0] meta_wchan,
   input  logic [SW-1:0]     meta_raddr,
   output logic [LEN_W-1:0]  meta_rlen,
   output logic [CHAN_W-1:0] meta_rchan
);

   logic [BYTE_W-1:0]       pay_mem [QUEUE_SLOTS * SLOT_BYTES];
   logic [LEN_W+CHAN_W-1:0] meta_mem [QUEUE_SLOTS];
   logic [LEN_W+CHAN_W-1:0] meta_rd_ff;

   // Payload bytes; read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (ctl.pay_we) begin
         pay_mem[pay_waddr] <= pay_wdata;
      end
      if (ctl.pay_re) begin
         pay_rdata <= pay_mem[pay_raddr];
      end
   end

   // Per-slot length and channel
   always_ff @(posedge clock) begin
      if (ctl.meta_we) begin
         meta_mem[meta_waddr] <= {meta_wlen, meta_wchan};
      end
      if (ctl.meta_re) begin
         meta_rd_ff <= meta_mem[meta_raddr];
      end
   end

   assign meta_rlen  = meta_rd_ff[LEN_W+CHAN_W-1:CHAN_W];
   assign meta_rchan = meta_rd_ff[CHAN_W-1:0];

endmodule

[rtl/message_slot_fifo.sv]
// Ring of message slots with byte-wide write and streamed read.
// Write: bytes are taken while idle; the final byte's status appears in the cycle after it.
// Read: the head length/channel lookup is registered and then passes S_HDR; after
// that, one byte per cycle from the payload memory port while the output is not stalled.
// Reset (synchronous) empties the ring; payload memory is not cleared.
module message_slot_fifo
   import msf_pkg::*;
#(
   parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
   parameter int SLOT_BYTES  = SLOT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [CHAN_W-1:0] req_channel,
   input  logic              req_final_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CODE_W-1:0] rsp_kind,
   output logic [CODE_W-1:0] rsp_status,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic [CHAN_W-1:0] rsp_out_channel,
   output logic [LEN_W-1:0]  rsp_msg_length,
   output logic              rsp_end_of_run
);

   localparam int SW = $clog2(QUEUE_SLOTS);
   localparam int CW = $clog2(QUEUE_SLOTS + 1);
   localparam int IW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
   localparam int AW = $clog2(QUEUE_SLOTS * SLOT_BYTES);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_HDR    = 2'd1;
   localparam logic [1:0] S_STREAM = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [SW-1:0]     head_ff, head_in;
   logic [SW-1:0]     tail_ff, tail_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [CODE_W-1:0] rej_ff, rej_in;
   logic [CHAN_W-1:0] wchan_ff, wchan_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] kind_ff, kind_in;
   logic [CODE_W-1:0] status_ff, status_in;
   logic              end_ff, end_in;

   mem_ctl_type       ctl;
   logic [AW-1:0]     pay_waddr, pay_raddr;
   logic [BYTE_W-1:0] pay_rdata;
   logic [LEN_W-1:0]  meta_rlen, fill_next;
   logic [CHAN_W-1:0] meta_rchan, chan_cur;
   logic [CODE_W-1:0] rej_cur, rej_next;
   logic              out_free, req_take, last_byte;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_take  = req_valid && req_ready;

   assign pay_waddr = AW'(tail_ff) * AW'(SLOT_BYTES) + AW'(fill_ff[IW-1:0]);
   assign pay_raddr = AW'(head_ff) * AW'(SLOT_BYTES) + AW'(idx_ff);
   assign last_byte = (LEN_W'(idx_ff) + LEN_W'(1)) == meta_rlen;

   // Write-side bookkeeping for the current byte
   always_comb begin
      chan_cur  = (fill_ff == '0) ? req_channel : wchan_ff;
      rej_cur   = rej_ff;
      if (fill_ff == '0) begin
         rej_cur = (count_ff == CW'(QUEUE_SLOTS)) ? ST_FULL : ST_OK;
      end
      rej_next  = rej_cur;
      if (rej_cur == ST_OK && fill_ff >= LEN_W'(SLOT_BYTES)) begin
         rej_next = ST_LONG;
      end
      fill_next = (fill_ff < LEN_W'(SLOT_BYTES + 1)) ? fill_ff + LEN_W'(1) : fill_ff;
   end

   // Controller next state
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      rej_in       = rej_ff;
      wchan_in     = wchan_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      status_in    = status_ff;
      end_in       = end_ff;
      ctl          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take && req_mode == MODE_WRITE) begin
               ctl.pay_we = (rej_cur == ST_OK) && (fill_ff < LEN_W'(SLOT_BYTES));
               if (req_final_byte) begin
                  if (rej_next == ST_OK) begin
                     ctl.meta_we = 1'b1;
                     tail_in     = (tail_ff == SW'(QUEUE_SLOTS - 1)) ? '0 : tail_ff + SW'(1);
                     count_in    = count_ff + CW'(1);
                  end
                  fill_in      = '0;
                  rej_in       = ST_OK;
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_STATUS;
                  status_in    = rej_next;
                  end_in       = 1'b1;
               end else begin
                  fill_in  = fill_next;
                  rej_in   = rej_next;
                  wchan_in = chan_cur;
               end
            end else if (req_take) begin
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  kind_in      = KIND_EMPTY;
                  status_in    = ST_OK;
                  end_in       = 1'b1;
               end else begin
                  ctl.meta_re = 1'b1;
                  state_in    = S_HDR;
               end
            end
         end
         S_HDR: begin
            idx_in   = '0;
            state_in = S_STREAM;
         end
         S_STREAM: begin
            if (out_free) begin
               ctl.pay_re   = 1'b1;
               rsp_valid_in = 1'b1;
               kind_in      = KIND_BYTE;
               status_in    = ST_OK;
               end_in       = last_byte;
               idx_in       = idx_ff + IW'(1);
               if (last_byte) begin
                  head_in  = (head_ff == SW'(QUEUE_SLOTS - 1)) ? '0 : head_ff + SW'(1);
                  count_in = count_ff - CW'(1);
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         rej_ff       <= ST_OK;
         wchan_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rej_ff       <= rej_in;
         wchan_ff     <= wchan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result fields and stream index
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      end_ff    <= end_in;
   end

   msf_slot_mem #(
      .QUEUE_SLOTS (QUEUE_SLOTS),
      .SLOT_BYTES  (SLOT_BYTES)
   ) u_mem (
      .clock      (clock),
      .ctl        (ctl),
      .pay_waddr  (pay_waddr),
      .pay_wdata  (req_data_byte),
      .pay_raddr  (pay_raddr),
      .pay_rdata  (pay_rdata),
      .meta_waddr (tail_ff),
      .meta_wlen  (fill_next),
      .meta_wchan (chan_cur),
      .meta_raddr (head_ff),
      .meta_rlen  (meta_rlen),
      .meta_rchan (meta_rchan)
   );

   // Output drive; payload fields are zero outside byte transactions
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_status      = status_ff;
   assign rsp_end_of_run  = end_ff;
   assign rsp_out_byte    = (kind_ff == KIND_BYTE) ? pay_rdata : '0;
   assign rsp_out_channel = (kind_ff == KIND_BYTE) ? meta_rchan : '0;
   assign rsp_msg_length  = (kind_ff == KIND_BYTE) ? meta_rlen : '0;

`ifndef SYNTHESIS
   // Occupancy never exceeds the ring
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_SLOTS))
      else $error("slot count above ring size");

   // Streaming only from a non-empty ring
   a_stream_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM) |-> (count_ff != '0))
      else $error("streaming with empty ring");

   // Empty result only while the ring is empty
   a_empty_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == KIND_EMPTY) |-> (count_ff == '0))
      else $error("empty result with stored messages");

   // Fill count saturates one past the slot size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_W'(SLOT_BYTES + 1))
      else $error("write fill out of range");
`endif

endmodule
